[rtl/core/float_to_pcm_sample_converter_defines.svh]
// Assertion macros for the float to PCM sample converter checker.
// Needs a clock named i_clk and a synchronous active-low reset i_rst_n in scope.
`ifndef FLOAT_TO_PCM_SAMPLE_CONVERTER_DEFINES_SVH
`define FLOAT_TO_PCM_SAMPLE_CONVERTER_DEFINES_SVH

// Implication that is checked only outside reset.
`define F2P_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("f2p assertion failed");

// Implication that is checked on the next cycle, outside reset.
`define F2P_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("f2p assertion failed");

// Implication that is checked at every edge, reset included.
`define F2P_ASSERT_ALWAYS(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |-> (cons)) \
        else $error("f2p assertion failed");

`endif

[rtl/core/f2p_pkg.sv]
// Shared types and constants for the float to PCM sample converter.
// No dependencies.
`default_nettype none

package f2p_pkg;

    // Output format codes; code 3 behaves as PCM32.
    typedef enum logic [1:0] {
        FMT_PCM16 = 2'd0,
        FMT_PCM24 = 2'd1,
        FMT_PCM32 = 2'd2
    } t_fmt;

    localparam logic [30:0] SCALE_PCM16 = 31'd32767;
    localparam logic [30:0] SCALE_PCM24 = 31'd8388607;
    localparam logic [30:0] SCALE_PCM32 = 31'd2147483647;

    localparam logic [31:0] POSMAX_PCM16 = 32'd32767;
    localparam logic [31:0] POSMAX_PCM24 = 32'd8388607;
    localparam logic [31:0] POSMAX_PCM32 = 32'd2147483647;
    localparam logic [31:0] NEGMAG_PCM16 = 32'd32768;
    localparam logic [31:0] NEGMAG_PCM24 = 32'd8388608;
    localparam logic [31:0] NEGMAG_PCM32 = 32'h8000_0000;

    localparam int JUSTIFY_SHIFT = 8;

    // Side data that travels with a sample through the pipeline.
    typedef struct packed {
        logic       sign;
        logic       last;
        logic [1:0] fmt;
    } t_ctl;

    // Decoded sample after the first stage.
    typedef struct packed {
        t_ctl               ctl;
        logic               nan;
        logic               inf;
        logic [23:0]        mant;
        logic signed [8:0]  exp2;
    } t_dec;

endpackage

`default_nettype wire

[rtl/core/f2p_stream_if.sv]
// Valid/ready stream interfaces for float input and PCM output samples.
// No dependencies.
`default_nettype none

interface f2p_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] float_bits;
    logic        last_in;

    modport source (output valid, output float_bits, output last_in, input ready);
    modport sink   (input valid, input float_bits, input last_in, output ready);
endinterface

interface f2p_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pcm_sample;
    logic               last_out;

    modport source (output valid, output pcm_sample, output last_out, input ready);
    modport sink   (input valid, input pcm_sample, input last_out, output ready);
endinterface

`default_nettype wire

[rtl/core/f2p_scale.sv]
// Multiply and round stages: mantissa times full-scale, then shift with rounding.
// Depends on f2p_pkg.
`default_nettype none

module f2p_scale (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_vld,
    input  wire f2p_pkg::t_dec i_dec,
    output logic               o_vld,
    output f2p_pkg::t_ctl      o_ctl,
    output logic [31:0]        o_mag,
    output logic               o_sat
);
    import f2p_pkg::*;

    logic              r_v2, r_v3;
    t_ctl              r_ctl2, r_ctl3;
    logic              r_nan2, r_inf2;
    logic signed [8:0] r_exp2;
    logic [54:0]       r_prod;
    logic [31:0]       r_mag;
    logic              r_sat;

    logic [30:0] scale;
    logic [54:0] n_prod;
    logic [31:0] n_mag;
    logic        n_sat;
    logic [85:0] lsh;
    logic [8:0]  rsh;
    logic [5:0]  rsh6;
    logic [54:0] q;
    logic [54:0] rq;
    logic [55:0] qsum;

    // Full-scale constant by format.
    always_comb begin
        case (i_dec.ctl.fmt)
            FMT_PCM16: scale = SCALE_PCM16;
            FMT_PCM24: scale = SCALE_PCM24;
            default:   scale = SCALE_PCM32;
        endcase
        n_prod = 55'(i_dec.mant) * 55'(scale);
    end

    // Stage two: exact product register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v2 <= i_vld;
        end
        if (i_en) begin
            r_prod <= n_prod;
            r_exp2 <= i_dec.exp2;
            r_nan2 <= i_dec.nan;
            r_inf2 <= i_dec.inf;
            r_ctl2 <= i_dec.ctl;
        end
    end

    // Scale by the power of two, rounding half away from zero on right shifts.
    always_comb begin
        lsh  = {31'd0, r_prod} << r_exp2[4:0];
        rsh  = 9'(-r_exp2);
        rsh6 = rsh[5:0];
        q    = r_prod >> rsh6;
        rq   = r_prod >> 6'(rsh6 - 6'd1);
        qsum = {1'b0, q} + {55'd0, rq[0]};
        n_mag = '0;
        n_sat = 1'b0;
        if (r_nan2) begin
            n_sat = 1'b0;
        end else if (r_inf2) begin
            n_sat = 1'b1;
        end else if (r_exp2 >= 9'sd0) begin
            n_sat = (r_exp2 >= 9'sd32) || (lsh[85:32] != '0);
            n_mag = lsh[31:0];
        end else if (rsh < 9'd63) begin
            n_sat = (qsum[55:32] != '0);
            n_mag = qsum[31:0];
        end
    end

    // Stage three: rounded magnitude register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v3 <= r_v2;
        end
        if (i_en) begin
            r_mag  <= n_mag;
            r_sat  <= n_sat;
            r_ctl3 <= r_ctl2;
        end
    end

    assign o_vld = r_v3;
    assign o_ctl = r_ctl3;
    assign o_mag = r_mag;
    assign o_sat = r_sat;

endmodule

`default_nettype wire

[rtl/core/float_to_pcm_sample_converter.sv]
// Throughput: one sample per cycle; the whole four-stage pipeline holds while
// the output register is full and not taken.
// Reset (synchronous, active low) empties the pipeline and sets the format to PCM16.
// Stages: decode, 24x31 multiply, shift and round, saturate and justify.
`default_nettype none

module float_to_pcm_sample_converter (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [1:0] i_cfg_wdata,
    f2p_in_if.sink          i_smp,
    f2p_out_if.source       o_pcm
);
    import f2p_pkg::*;

    logic [1:0]  r_fmt;
    logic        r_v1, r_v4;
    t_dec        r_dec;
    logic [31:0] r_pcm;
    logic        r_last4;

    logic        en;
    t_dec        n_dec;
    logic        v3;
    t_ctl        ctl3;
    logic [31:0] mag3;
    logic        sat3;
    logic [31:0] posmax, negmag, lim, n_pcm;

    assign en          = !r_v4 || o_pcm.ready;
    assign i_smp.ready = en;

    // Format register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt <= FMT_PCM16;
        end else if (i_cfg_we) begin
            r_fmt <= i_cfg_wdata;
        end
    end

    // Decode the float fields.
    always_comb begin
        n_dec.ctl.sign = i_smp.float_bits[31];
        n_dec.ctl.last = i_smp.last_in;
        n_dec.ctl.fmt  = r_fmt;
        n_dec.nan = (i_smp.float_bits[30:23] == 8'hFF) && (i_smp.float_bits[22:0] != '0);
        n_dec.inf = (i_smp.float_bits[30:23] == 8'hFF) && (i_smp.float_bits[22:0] == '0);
        if (i_smp.float_bits[30:23] == 8'd0) begin
            n_dec.mant = {1'b0, i_smp.float_bits[22:0]};
            n_dec.exp2 = -9'sd149;
        end else begin
            n_dec.mant = {1'b1, i_smp.float_bits[22:0]};
            n_dec.exp2 = $signed({1'b0, i_smp.float_bits[30:23]}) - 9'sd150;
        end
    end

    // Stage one: decoded sample register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_smp.valid;
        end
        if (en) begin
            r_dec <= n_dec;
        end
    end

    f2p_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r_v1),
        .i_dec   (r_dec),
        .o_vld   (v3),
        .o_ctl   (ctl3),
        .o_mag   (mag3),
        .o_sat   (sat3)
    );

    // Saturate to the format range, apply sign and left-justify PCM24.
    always_comb begin
        case (ctl3.fmt)
            FMT_PCM16: begin
                posmax = POSMAX_PCM16;
                negmag = NEGMAG_PCM16;
            end
            FMT_PCM24: begin
                posmax = POSMAX_PCM24;
                negmag = NEGMAG_PCM24;
            end
            default: begin
                posmax = POSMAX_PCM32;
                negmag = NEGMAG_PCM32;
            end
        endcase
        lim = ctl3.sign ? negmag : posmax;
        n_pcm = (sat3 || (mag3 > lim)) ? lim : mag3;
        if (ctl3.sign) begin
            n_pcm = 32'd0 - n_pcm;
        end
        if (ctl3.fmt == FMT_PCM24) begin
            n_pcm = n_pcm << JUSTIFY_SHIFT;
        end
    end

    // Stage four: output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (en) begin
            r_v4 <= v3;
        end
        if (en) begin
            r_pcm   <= n_pcm;
            r_last4 <= ctl3.last;
        end
    end

    assign o_pcm.valid      = r_v4;
    assign o_pcm.pcm_sample = r_pcm;
    assign o_pcm.last_out   = r_last4;

endmodule

`default_nettype wire

[rtl/core/f2p_checker.sv]
// Port-level checker for the float to PCM sample converter, bound to the top level.
// Depends on f2p_pkg and float_to_pcm_sample_converter_defines.svh.
`default_nettype none
`include "float_to_pcm_sample_converter_defines.svh"

module f2p_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_cfg_we,
    input wire logic [1:0]  i_cfg_wdata,
    input wire logic        i_in_ready,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [31:0] i_out_pcm,
    input wire logic        i_out_last
);
    import f2p_pkg::*;

    logic [1:0] r_fmt;
    logic       out_stall;
    logic       pcm16_fit;

    // Shadow of the format register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt <= FMT_PCM16;
        end else if (i_cfg_we) begin
            r_fmt <= i_cfg_wdata;
        end
    end

    // A result is waiting, and the sign-extended 16-bit range test.
    assign out_stall = i_out_valid && !i_out_ready;
    assign pcm16_fit = (i_out_pcm[31:15] == 17'h0) || (i_out_pcm[31:15] == 17'h1FFFF);

    `F2P_ASSERT_NXT(a_hold, out_stall, i_out_valid && $stable(i_out_pcm) && $stable(i_out_last))
    `F2P_ASSERT_IMP(a_ready, !i_out_valid, i_in_ready)
    `F2P_ASSERT_IMP(a_pcm16, i_out_valid && (r_fmt == FMT_PCM16), pcm16_fit)
    `F2P_ASSERT_IMP(a_pcm24, i_out_valid && (r_fmt == FMT_PCM24), i_out_pcm[7:0] == 8'h00)
    `F2P_ASSERT_ALWAYS(a_rst, $past(!i_rst_n), !i_out_valid)

endmodule

bind float_to_pcm_sample_converter f2p_checker u_f2p_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_cfg_we    (i_cfg_we),
    .i_cfg_wdata (i_cfg_wdata),
    .i_in_ready  (i_smp.ready),
    .i_out_valid (o_pcm.valid),
    .i_out_ready (o_pcm.ready),
    .i_out_pcm   (o_pcm.pcm_sample),
    .i_out_last  (o_pcm.last_out)
);

`default_nettype wire

[verif/float_to_pcm_sample_converter_tb.sv]
// Testbench for the float to PCM sample converter: directed and random float
// samples in every output format, checked against an integer-exact predictor.
// Depends on f2p_pkg, the f2p stream interfaces and the converter RTL.
`default_nettype none

class pcm_scoreboard;
    logic signed [31:0] pcm_q[$];
    logic               last_q[$];
    int                 errors;
    int                 checked;

    function new();
        errors  = 0;
        checked = 0;
    endfunction

    // Rounded magnitude of mant * 2^e2 * scale; left shifts are capped at 2^40.
    function automatic logic [63:0] scaled_mag(logic [23:0] mant, int e2, logic [63:0] scale);
        logic [63:0] prod;
        logic [63:0] q;
        logic [63:0] rem;
        int          sh;
        prod = {40'd0, mant} * scale;
        if (prod == 0) return 64'd0;
        if (e2 >= 0) begin
            if (e2 >= 32) return 64'd1 << 40;
            if (prod > ((64'd1 << 40) >> e2)) return 64'd1 << 40;
            return prod << e2;
        end
        sh = -e2;
        if (sh >= 63) return 64'd0;
        q = prod >> sh;
        rem = prod & ((64'd1 << sh) - 1);
        if (rem >= (64'd1 << (sh - 1))) q = q + 1;
        return q;
    endfunction

    // Expected PCM value for one float sample in the given format.
    function automatic logic [31:0] convert(logic [31:0] bits, logic [1:0] fmt);
        logic [63:0] scale;
        logic [63:0] posmax;
        logic [63:0] negmag;
        logic [63:0] mag;
        logic [7:0]  ex;
        logic [22:0] frac;
        logic [31:0] res;
        ex = bits[30:23];
        frac = bits[22:0];
        if (fmt == f2p_pkg::FMT_PCM16) begin
            scale = 32767; posmax = 32767; negmag = 32768;
        end else if (fmt == f2p_pkg::FMT_PCM24) begin
            scale = 8388607; posmax = 8388607; negmag = 8388608;
        end else begin
            scale = 2147483647; posmax = 2147483647; negmag = 64'h8000_0000;
        end
        if (ex == 8'hFF) mag = (frac != 0) ? 64'd0 : (64'd1 << 40);
        else if (ex == 0) mag = scaled_mag({1'b0, frac}, -149, scale);
        else mag = scaled_mag({1'b1, frac}, int'(ex) - 150, scale);
        if (bits[31]) begin
            if (mag > negmag) mag = negmag;
            res = 32'd0 - mag[31:0];
        end else begin
            if (mag > posmax) mag = posmax;
            res = mag[31:0];
        end
        if (fmt == f2p_pkg::FMT_PCM24) res = res << 8;
        return res;
    endfunction

    function void note_sample(logic [31:0] bits, logic last, logic [1:0] fmt);
        pcm_q.push_back(convert(bits, fmt));
        last_q.push_back(last);
    endfunction

    function void check_pcm(logic signed [31:0] pcm, logic last);
        logic signed [31:0] exp_pcm;
        logic               exp_last;
        if (pcm_q.size() == 0) begin
            $display("%0t: unexpected result pcm=%h last=%b", $time, pcm, last);
            errors++;
            return;
        end
        exp_pcm = pcm_q.pop_front();
        exp_last = last_q.pop_front();
        checked++;
        if (pcm !== exp_pcm) begin
            $display("%0t: pcm_sample expected %h actual %h", $time, exp_pcm, pcm);
            errors++;
        end
        if (last !== exp_last) begin
            $display("%0t: last_out expected %b actual %b", $time, exp_last, last);
            errors++;
        end
    endfunction
endclass

module float_to_pcm_sample_converter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [1:0] i_cfg_wdata;
    logic [1:0] cur_fmt;
    int         idle_pct;
    int         sent;

    f2p_in_if  smp_if ();
    f2p_out_if pcm_if ();

    pcm_scoreboard sb;

    float_to_pcm_sample_converter dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_smp      (smp_if.sink),
        .o_pcm      (pcm_if.source)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Overall time limit.
    initial begin
        #2ms;
        $display("Mismatches found");
        $finish;
    end

    // Note accepted requests and check results at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n && smp_if.valid && smp_if.ready)
            sb.note_sample(smp_if.float_bits, smp_if.last_in, cur_fmt);
        if (i_rst_n && pcm_if.valid && pcm_if.ready)
            sb.check_pcm(pcm_if.pcm_sample, pcm_if.last_out);
    end

    // Random stall on the result side.
    initial begin
        pcm_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            pcm_if.ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    task automatic write_format(input logic [1:0] fmt);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= fmt;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        cur_fmt = fmt;
    endtask

    // Send one request; valid stays high between back-to-back requests.
    task automatic send_sample(input logic [31:0] bits, input logic last);
        while ($urandom_range(99) < idle_pct) begin
            smp_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        smp_if.valid <= 1'b1;
        smp_if.float_bits <= bits;
        smp_if.last_in <= last;
        @(posedge i_clk);
        while (!smp_if.ready) @(posedge i_clk);
        @(negedge i_clk);
        sent++;
    endtask

    task automatic drain();
        smp_if.valid <= 1'b0;
        while (sb.pcm_q.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    // Random float: mostly magnitudes below full scale, plus raw bit patterns.
    function automatic logic [31:0] random_float();
        int pick;
        pick = $urandom_range(9);
        if (pick < 6)
            return {1'($urandom), 8'($urandom_range(126, 100)), 23'($urandom)};
        if (pick < 7) return {1'($urandom), 8'($urandom_range(127, 160)), 23'($urandom)};
        if (pick < 8) return {1'($urandom), 8'($urandom_range(0, 2)), 23'($urandom)};
        return $urandom;
    endfunction

    logic [31:0] directed[] = '{
        32'h0000_0000, 32'h8000_0000, 32'h3F80_0000, 32'hBF80_0000,
        32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000, 32'hFFFF_FFFF,
        32'h7F80_0001, 32'h0000_0001, 32'h807F_FFFF, 32'h3F00_0000,
        32'hBF00_0000, 32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h4000_0000,
        32'h3800_0000, 32'h3700_0100, 32'h3F7F_FFFF, 32'hC2C8_0000
    };

    // Every format code, the unused code last.
    logic [1:0] fmt_seq[] = '{
        f2p_pkg::FMT_PCM16, f2p_pkg::FMT_PCM24, f2p_pkg::FMT_PCM32, 2'd3
    };

    initial begin
        sb = new();
        idle_pct = 12;
        sent = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = 2'd0;
        cur_fmt = f2p_pkg::FMT_PCM16;
        smp_if.valid = 1'b0;
        smp_if.float_bits = 32'd0;
        smp_if.last_in = 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed corners in reset format, then each written format.
        foreach (directed[i]) send_sample(directed[i], i[0]);
        drain();
        foreach (fmt_seq[f]) begin
            write_format(fmt_seq[f]);
            foreach (directed[i]) send_sample(directed[i], ~i[0]);
            drain();
        end

        // Random phases, each in a randomly chosen format; one phase runs with no idling.
        for (int ph = 0; ph < 8; ph++) begin
            write_format(2'($urandom_range(3)));
            idle_pct = (ph == 3) ? 0 : 12;
            repeat (160) send_sample(random_float(), 1'($urandom));
            drain();
        end
        idle_pct = 12;
        repeat (8) @(negedge i_clk);

        $display("Sent %0d float samples over all output formats; %0d results checked.",
                 sent, sb.checked);
        if (sb.errors == 0 && sb.pcm_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

`default_nettype wire

[files.f]
+incdir+rtl/core
rtl/core/f2p_pkg.sv
rtl/core/f2p_stream_if.sv
rtl/core/f2p_scale.sv
rtl/core/float_to_pcm_sample_converter.sv
rtl/core/f2p_checker.sv
verif/float_to_pcm_sample_converter_tb.sv
